FILE: sv/firmware_image_verifier_unit_assert.svh
// Assertion macros for the firmware image verifier.
`ifndef FIRMWARE_IMAGE_VERIFIER_UNIT_ASSERT_SVH
`define FIRMWARE_IMAGE_VERIFIER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FIV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FIV_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FIV_ASSERT(label, clk, rst, prop, msg)
`define FIV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: sv/fiv_pkg.sv
package fiv_pkg;

   localparam int PrefixMaxDefault  = 32;
   localparam int VersionMaxDefault = 23;
   localparam int LengthBitsDefault = 24;

   localparam logic [1:0] OP_START    = 2'd0;
   localparam logic [1:0] OP_RECEIVE  = 2'd1;
   localparam logic [1:0] OP_READBACK = 2'd2;
   localparam logic [1:0] OP_ABORT    = 2'd3;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_NO_UPLOAD   = 4'd1;
   localparam logic [3:0] ST_BAD_SIZE    = 4'd2;
   localparam logic [3:0] ST_NO_FIT      = 4'd3;
   localparam logic [3:0] ST_OVERFLOW    = 4'd4;
   localparam logic [3:0] ST_BAD_HEADER  = 4'd5;
   localparam logic [3:0] ST_INCOMPLETE  = 4'd6;
   localparam logic [3:0] ST_MISMATCH    = 4'd7;
   localparam logic [3:0] ST_ID_MISSING  = 4'd8;
   localparam logic [3:0] ST_IN_PROGRESS = 4'd9;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_RECV  = 2'd1;
   localparam logic [1:0] PH_READY = 2'd2;

   localparam logic [2:0] CSR_MAX_IMAGE = 3'd0;
   localparam logic [2:0] CSR_STAGE_CAP = 3'd1;
   localparam logic [2:0] CSR_PREFIX_LEN = 3'd2;
   localparam logic [2:0] CSR_PREFIX_W0 = 3'd3;
   localparam logic [2:0] CSR_PREFIX_W1 = 3'd4;
   localparam logic [2:0] CSR_PREFIX_W2 = 3'd5;
   localparam logic [2:0] CSR_PREFIX_W3 = 3'd6;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] announced_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  status;
      logic [1:0]  phase;
      logic [31:0] image_crc;
      logic [4:0]  version_length;
      logic [7:0]  version_char;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [63:0] data;
   } csr_type;

   // Work item handed from the front to the back: a status and, on an ok
   // verdict, the number of version characters to emit after it.
   typedef struct packed {
      logic [3:0]  status;
      logic [1:0]  phase;
      logic [31:0] image_crc;
      logic [4:0]  version_length;
   } job_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

FILE: sv/fiv_front.sv
module fiv_front import fiv_pkg::*; #(
   parameter int PREFIX_MAX  = PrefixMaxDefault,
   parameter int VERSION_MAX = VersionMaxDefault,
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  req_type       item,
   input  logic          csr_we,
   input  csr_type       csr,
   output logic          job_valid,
   output job_type       job,
   output logic          vs_we,
   output logic [$clog2(VERSION_MAX)-1:0] vs_addr,
   output logic [7:0]    vs_data
);
   localparam int MIW = $clog2(PREFIX_MAX + 1);
   localparam int VCW = $clog2(VERSION_MAX + 1);

   logic [23:0] max_image_ff, stage_cap_ff;
   logic [5:0]  prefix_len_ff;
   logic [255:0] prefix_ff;

   logic [1:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in, rcv_cnt_ff, rcv_cnt_in, rb_cnt_ff, rb_cnt_in;
   logic [31:0]            rcv_crc_ff, rcv_crc_in, rb_crc_ff, rb_crc_in;
   logic [7:0]             hdr2_ff, hdr2_in;
   logic [MIW-1:0]         match_ff, match_in;
   logic                   in_ver_ff, in_ver_in, found_ff, found_in;
   logic [VCW-1:0]         vcount_ff, vcount_in;
   logic                   job_valid_in;
   job_type                job_in;

   logic [MIW-1:0] plen;
   logic [7:0]     c, pb_match, pb0;
   logic [LENGTH_BITS-1:0] len;
   logic [31:0]    rb_crc_next;

   always_comb begin
      if (prefix_len_ff == 6'd0) plen = MIW'(1);
      else if (32'(prefix_len_ff) > 32'(PREFIX_MAX)) plen = MIW'(PREFIX_MAX);
      else plen = MIW'(prefix_len_ff);
   end

   assign c   = item.data_byte;
   assign len = LENGTH_BITS'(item.announced_length);
   assign pb0 = prefix_ff[7:0];
   assign pb_match = (32'(match_ff) >= 32) ? 8'd0 : prefix_ff[8*(32'(match_ff) & 31) +: 8];
   assign rb_crc_next = crc_byte(rb_crc_ff, c);

   always_comb begin
      phase_in = phase_ff; total_in = total_ff; rcv_cnt_in = rcv_cnt_ff; rb_cnt_in = rb_cnt_ff;
      rcv_crc_in = rcv_crc_ff; rb_crc_in = rb_crc_ff; hdr2_in = hdr2_ff; match_in = match_ff;
      in_ver_in = in_ver_ff; found_in = found_ff; vcount_in = vcount_ff;
      job_valid_in = item_valid;
      job_in = '{status: ST_OK, phase: PH_IDLE, image_crc: 32'd0, version_length: 5'd0};
      vs_we = 1'b0; vs_addr = vcount_ff[$clog2(VERSION_MAX)-1:0]; vs_data = c;
      if (item_valid) begin
         unique case (item.op)
            OP_START: begin
               phase_in = PH_IDLE;
               if (32'(item.announced_length) < 256 || item.announced_length > max_image_ff)
                  job_in.status = ST_BAD_SIZE;
               else if (item.announced_length > stage_cap_ff)
                  job_in.status = ST_NO_FIT;
               else begin
                  total_in = len; rcv_cnt_in = '0; rb_cnt_in = '0;
                  rcv_crc_in = '1; rb_crc_in = '1; hdr2_in = '0; match_in = '0;
                  in_ver_in = 1'b0; found_in = 1'b0; vcount_in = '0; phase_in = PH_RECV;
               end
            end
            OP_RECEIVE: begin
               if (phase_ff != PH_RECV) job_in.status = ST_NO_UPLOAD;
               else if (rcv_cnt_ff >= total_ff) begin
                  phase_in = PH_IDLE; job_in.status = ST_OVERFLOW;
               end else begin
                  rcv_crc_in = crc_byte(rcv_crc_ff, c);
                  rcv_cnt_in = rcv_cnt_ff + 1'b1;
                  if (rcv_cnt_in == LENGTH_BITS'(3)) hdr2_in = c;
                  if (rcv_cnt_in == LENGTH_BITS'(4) && (hdr2_ff != 8'h9f || c != 8'he5)) begin
                     phase_in = PH_IDLE; job_in.status = ST_BAD_HEADER;
                  end
               end
            end
            OP_READBACK: begin
               if (phase_ff != PH_RECV || rcv_cnt_ff != total_ff || rb_cnt_ff >= total_ff)
                  job_in.status = ST_INCOMPLETE;
               else begin
                  rb_crc_in = rb_crc_next;
                  if (!found_ff) begin
                     if (in_ver_ff) begin
                        if (c == 8'h3b && vcount_ff != '0) found_in = 1'b1;
                        else if (c < 8'h20 || c > 8'h7e || c == 8'h3b ||
                                 32'(vcount_ff) >= VERSION_MAX) begin
                           in_ver_in = 1'b0;
                           match_in = (c == pb0) ? MIW'(1) : '0;
                           if (match_in >= plen) begin in_ver_in = 1'b1; vcount_in = '0; end
                        end else begin
                           vs_we = 1'b1; vcount_in = vcount_ff + 1'b1;
                        end
                     end else if (c == pb_match) begin
                        match_in = match_ff + 1'b1;
                        if (match_in >= plen) begin in_ver_in = 1'b1; vcount_in = '0; end
                     end else begin
                        match_in = (c == pb0) ? MIW'(1) : '0;
                        if (match_in >= plen) begin in_ver_in = 1'b1; vcount_in = '0; end
                     end
                  end
                  rb_cnt_in = rb_cnt_ff + 1'b1;
                  if (rb_cnt_in != total_ff) job_in.status = ST_IN_PROGRESS;
                  else if (rb_crc_next != rcv_crc_ff) begin
                     phase_in = PH_IDLE; job_in.status = ST_MISMATCH;
                  end else if (!found_in) begin
                     phase_in = PH_IDLE; job_in.status = ST_ID_MISSING;
                  end else begin
                     phase_in = PH_READY;
                     job_in.image_crc = ~rb_crc_next;
                     job_in.version_length = 5'(vcount_in);
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
         job_in.phase = phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_image_ff <= 24'd262144; stage_cap_ff <= '0; prefix_len_ff <= 6'd1; prefix_ff <= '0;
         phase_ff <= PH_IDLE; total_ff <= '0; rcv_cnt_ff <= '0; rb_cnt_ff <= '0;
         rcv_crc_ff <= '1; rb_crc_ff <= '1; hdr2_ff <= '0; match_ff <= '0;
         in_ver_ff <= 1'b0; found_ff <= 1'b0; vcount_ff <= '0; job_valid <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr.index)
               CSR_MAX_IMAGE:  max_image_ff <= csr.data[23:0];
               CSR_STAGE_CAP:  stage_cap_ff <= csr.data[23:0];
               CSR_PREFIX_LEN: prefix_len_ff <= csr.data[5:0];
               CSR_PREFIX_W0:  prefix_ff[63:0] <= csr.data;
               CSR_PREFIX_W1:  prefix_ff[127:64] <= csr.data;
               CSR_PREFIX_W2:  prefix_ff[191:128] <= csr.data;
               CSR_PREFIX_W3:  prefix_ff[255:192] <= csr.data;
               default: ;
            endcase
         end
         phase_ff <= phase_in; total_ff <= total_in; rcv_cnt_ff <= rcv_cnt_in;
         rb_cnt_ff <= rb_cnt_in; rcv_crc_ff <= rcv_crc_in; rb_crc_ff <= rb_crc_in;
         hdr2_ff <= hdr2_in; match_ff <= match_in; in_ver_ff <= in_ver_in;
         found_ff <= found_in; vcount_ff <= vcount_in; job_valid <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job <= job_in;
   end

endmodule

FILE: sv/fiv_back.sv
`include "firmware_image_verifier_unit_assert.svh"
module fiv_back import fiv_pkg::*; #(
   parameter int VERSION_MAX = VersionMaxDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_ready,
   input  logic    vs_we,
   input  logic [$clog2(VERSION_MAX)-1:0] vs_addr,
   input  logic [7:0] vs_data,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);
   localparam int AW = $clog2(VERSION_MAX);

   typedef enum logic [1:0] {S_IDLE, S_STATUS, S_CHARS} state_type;

   logic [7:0]  store [VERSION_MAX];
   state_type   state_ff;
   job_type     job_ff;
   logic [4:0]  idx_ff;
   logic [7:0]  rd_ff;
   logic        take, advance;

   // The store is written by the front only while the back is idle (the top
   // level holds off items until then); the front only writes during readback,
   // after the last ok verdict is delivered, so no overlap occurs.
   always_ff @(posedge clock) begin
      if (vs_we) store[vs_addr] <= vs_data;
   end

   assign job_ready = (state_ff == S_IDLE);
   assign take      = job_valid && job_ready;
   assign advance   = !rsp_empty && rsp_pop;
   assign rsp_empty = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (take) begin
               job_ff <= job; state_ff <= S_STATUS; idx_ff <= '0;
            end
            S_STATUS: if (advance) begin
               if (job_ff.status == ST_OK && job_ff.version_length != 5'd0) begin
                  state_ff <= S_CHARS; rd_ff <= store[AW'(0)]; idx_ff <= 5'd1;
               end else state_ff <= S_IDLE;
            end
            S_CHARS: if (advance) begin
               if (idx_ff == job_ff.version_length) state_ff <= S_IDLE;
               else begin
                  rd_ff <= store[AW'(idx_ff)]; idx_ff <= idx_ff + 5'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_data = '0;
      rsp_data.phase = job_ff.phase;
      if (state_ff == S_CHARS) begin
         rsp_data.kind = 1'b1;
         rsp_data.image_crc = job_ff.image_crc;
         rsp_data.version_length = job_ff.version_length;
         rsp_data.version_char = rd_ff;
         rsp_data.last = (idx_ff == job_ff.version_length);
      end else begin
         rsp_data.status = job_ff.status;
         rsp_data.image_crc = job_ff.image_crc;
         rsp_data.version_length = job_ff.version_length;
         rsp_data.last = (job_ff.version_length == 5'd0);
      end
   end

   `FIV_ASSERT(a_chars_ok, clock, reset, (state_ff == S_CHARS) |-> (job_ff.status == ST_OK), "chars after non-ok")
   `FIV_ASSERT(a_idx_range, clock, reset, (state_ff == S_CHARS) |-> (idx_ff != 5'd0 && idx_ff <= job_ff.version_length), "index out of range")
   `FIV_ASSERT(a_take_status, clock, reset, take |=> (state_ff == S_STATUS), "job not shown")
   `FIV_ASSERT_NR(a_reset_empty, clock, reset |=> rsp_empty, "not empty after reset")

endmodule

FILE: sv/firmware_image_verifier_unit.sv
// Each item is taken by the front, which updates the CRCs and the
// prefix matcher and registers a job that the back picks up on the next cycle.
// A status can be popped once the back has registered the job; an ok verdict then
// yields one character per pop. No new item is accepted until the previous
// result is fully popped, set by the single-entry handoff into the response sequencer.
// Synchronous active-high reset clears all control state and loads register defaults.
module firmware_image_verifier_unit import fiv_pkg::*; #(
   parameter int PREFIX_MAX  = PrefixMaxDefault,
   parameter int VERSION_MAX = VersionMaxDefault,
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  csr_type csr_data
);
   logic    job_valid, job_ready, vs_we, accept, busy_ff;
   job_type job;
   logic [$clog2(VERSION_MAX)-1:0] vs_addr;
   logic [7:0] vs_data;

   // One item in flight from acceptance until the back has delivered its responses.
   assign req_full  = busy_ff || job_valid || !job_ready;
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= accept;
   end

   fiv_front #(.PREFIX_MAX(PREFIX_MAX), .VERSION_MAX(VERSION_MAX),
               .LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock, .reset, .item_valid(accept), .item(req_data),
      .csr_we(csr_valid), .csr(csr_data), .job_valid, .job,
      .vs_we, .vs_addr, .vs_data);

   fiv_back #(.VERSION_MAX(VERSION_MAX)) u_back (
      .clock, .reset, .job_valid, .job, .job_ready, .vs_we, .vs_addr, .vs_data,
      .rsp_empty, .rsp_data, .rsp_pop);

endmodule
